// ===== src/gdfw_pkg.sv =====
// Shared types and constants for the depth-first graph walk core.
// Depends on nothing; every other file imports it.
package gdfw_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int MAX_DEGREE   = 8;

    localparam int VTX_W    = 4;                           // vertex number field
    localparam int CFG_W    = 5;                           // vertex_count register
    localparam int STATUS_W = 2;
    localparam int CNT_W    = $clog2(MAX_DEGREE + 1);      // list fill, 0..MAX_DEGREE
    localparam int TBL_DEPTH = MAX_VERTICES * MAX_DEGREE;
    localparam int TBL_AW   = $clog2(TBL_DEPTH);
    localparam int SP_W     = $clog2(MAX_VERTICES + 1);    // stack depth, 0..MAX_VERTICES
    localparam int STK_AW   = $clog2(MAX_VERTICES);

    localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(16);

    typedef enum logic [STATUS_W-1:0] {
        ST_VISIT = 2'd0,
        ST_ADDED = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EDGE_B,
        S_EDGE_CHK,
        S_EDGE_WRB,
        S_WALK,
        S_CHECK
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_EMIT_RANGE,
        OP_READ_CNT_A,
        OP_READ_CNT_B,
        OP_EMIT_FULL,
        OP_WRITE_A,
        OP_WRITE_B,
        OP_START,
        OP_POP,
        OP_FETCH,
        OP_VISIT,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        logic out_free;      // output register can take a result this cycle
        logic mode;          // latched item mode
        logic out_of_range;  // latched vertex(es) at or above vertex_count
        logic list_full;     // edge would overflow a neighbor list
        logic stack_empty;
        logic top_rem_zero;  // top of stack has no untried neighbors
        logic nbr_visited;   // fetched neighbor already marked
    } t_dp_sts;

endpackage

// ===== src/gdfw_ctrl.sv =====
// Controller FSM for the depth-first walk core.
// Depends on gdfw_pkg; drives gdfw_dp through t_dp_op, reads t_dp_sts.
module gdfw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gdfw_pkg::t_dp_sts i_sts,
    output gdfw_pkg::t_dp_op  o_op
);
    import gdfw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_sts.out_of_range) begin
                    if (i_sts.out_free) n_state = S_IDLE;
                end else if (!i_sts.mode) begin
                    n_state = S_EDGE_B;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_EDGE_B: begin
                n_state = S_EDGE_CHK;
            end
            S_EDGE_CHK: begin
                if (i_sts.list_full) begin
                    if (i_sts.out_free) n_state = S_IDLE;
                end else begin
                    n_state = S_EDGE_WRB;
                end
            end
            S_EDGE_WRB: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_WALK: begin
                if (i_sts.stack_empty) begin
                    if (i_sts.out_free) n_state = S_IDLE;
                end else if (!i_sts.top_rem_zero) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.nbr_visited || i_sts.out_free) n_state = S_WALK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) o_op = OP_LOAD;
            end
            S_DECODE: begin
                if (i_sts.out_of_range) begin
                    if (i_sts.out_free) o_op = OP_EMIT_RANGE;
                end else if (!i_sts.mode) begin
                    o_op = OP_READ_CNT_A;
                end else begin
                    o_op = OP_START;
                end
            end
            S_EDGE_B: begin
                o_op = OP_READ_CNT_B;
            end
            S_EDGE_CHK: begin
                if (i_sts.list_full) begin
                    if (i_sts.out_free) o_op = OP_EMIT_FULL;
                end else begin
                    o_op = OP_WRITE_A;
                end
            end
            S_EDGE_WRB: begin
                if (i_sts.out_free) o_op = OP_WRITE_B;
            end
            S_WALK: begin
                if (i_sts.stack_empty) begin
                    if (i_sts.out_free) o_op = OP_FINISH;
                end else if (i_sts.top_rem_zero) begin
                    o_op = OP_POP;
                end else begin
                    o_op = OP_FETCH;
                end
            end
            S_CHECK: begin
                if (!i_sts.nbr_visited && i_sts.out_free) o_op = OP_VISIT;
            end
            default: o_op = OP_NONE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== src/gdfw_dp.sv =====
// Datapath of the depth-first walk core: neighbor lists, marks, walk stack,
// output register. Depends on gdfw_pkg; commanded by gdfw_ctrl.
module gdfw_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gdfw_pkg::t_dp_op              i_op,
    output gdfw_pkg::t_dp_sts             o_sts,
    input  logic                          i_cfg_we,
    input  logic [gdfw_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_mode,
    input  logic [gdfw_pkg::VTX_W-1:0]    i_first_vertex,
    input  logic [gdfw_pkg::VTX_W-1:0]    i_second_vertex,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [gdfw_pkg::STATUS_W-1:0] o_status,
    output logic [gdfw_pkg::VTX_W-1:0]    o_visited_vertex,
    output logic                          o_last
);
    import gdfw_pkg::*;

    // config and latched item
    logic [CFG_W-1:0]  r_vcount;
    logic              r_mode;
    logic [VTX_W-1:0]  r_va;
    logic [VTX_W-1:0]  r_vb;
    logic [CNT_W-1:0]  r_cnt_a;
    logic [CNT_W-1:0]  r_cnt_b;

    // graph state
    logic [CNT_W-1:0]        r_count [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_visited;
    logic [VTX_W-1:0]        r_table [TBL_DEPTH];
    logic [VTX_W-1:0]        r_rd_data;

    // walk stack and pending (not yet emitted) vertex
    logic [VTX_W-1:0] r_stk_v   [MAX_VERTICES];
    logic [CNT_W-1:0] r_stk_rem [MAX_VERTICES];
    logic [SP_W-1:0]  r_depth;
    logic [VTX_W-1:0] r_pend;

    // output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [VTX_W-1:0]    r_out_vertex;
    logic                r_out_last;

    logic [VTX_W-1:0]  cnt_addr;
    logic [CNT_W-1:0]  cnt_rd;
    logic [SP_W-1:0]   top_pos;
    logic [STK_AW-1:0] top_idx;
    logic [STK_AW-1:0] push_idx;
    logic [VTX_W-1:0]  top_v;
    logic [CNT_W-1:0]  top_rem;
    logic [CNT_W-1:0]  top_rem_dec;
    logic [CNT_W:0]    need;
    logic              tbl_we;
    logic [TBL_AW-1:0] tbl_waddr;
    logic [VTX_W-1:0]  tbl_wdata;
    logic [TBL_AW-1:0] tbl_raddr;

    function automatic logic [TBL_AW-1:0] tbl_index(input logic [VTX_W-1:0] v,
                                                    input logic [CNT_W-1:0] slot);
        tbl_index = TBL_AW'(v) * TBL_AW'(MAX_DEGREE) + TBL_AW'(slot);
    endfunction

    // one count read port, address picked by the command
    always_comb begin
        case (i_op) inside
            OP_READ_CNT_B, OP_WRITE_B: cnt_addr = r_vb;
            OP_VISIT:                  cnt_addr = r_rd_data;
            default:                   cnt_addr = r_va;
        endcase
    end
    assign cnt_rd = r_count[cnt_addr];

    assign top_pos     = r_depth - SP_W'(1);
    assign top_idx     = top_pos[STK_AW-1:0];
    assign push_idx    = r_depth[STK_AW-1:0];
    assign top_v       = r_stk_v[top_idx];
    assign top_rem     = r_stk_rem[top_idx];
    assign top_rem_dec = top_rem - CNT_W'(1);

    assign need = (r_va == r_vb) ? (CNT_W+1)'(2) : (CNT_W+1)'(1);

    // table write: a-side entry, then b-side entry at the b count seen after it
    assign tbl_we    = (i_op == OP_WRITE_A) || (i_op == OP_WRITE_B);
    assign tbl_waddr = (i_op == OP_WRITE_A) ? tbl_index(r_va, r_cnt_a) : tbl_index(r_vb, cnt_rd);
    assign tbl_wdata = (i_op == OP_WRITE_A) ? r_vb : r_va;
    assign tbl_raddr = tbl_index(top_v, top_rem_dec);

    always_ff @(posedge i_clk) begin
        if (tbl_we) r_table[tbl_waddr] <= tbl_wdata;
        if (i_op == OP_FETCH) r_rd_data <= r_table[tbl_raddr];
    end

    // vertex numbers are below MAX_VERTICES, so comparing with the raw count
    // gives the same answer as with the count clamped to MAX_VERTICES
    assign o_sts.out_of_range = ({1'b0, r_va} >= r_vcount) ||
                                (!r_mode && ({1'b0, r_vb} >= r_vcount));
    assign o_sts.list_full    = (({1'b0, r_cnt_a} + need) > (CNT_W+1)'(MAX_DEGREE)) ||
                                (({1'b0, r_cnt_b} + need) > (CNT_W+1)'(MAX_DEGREE));
    assign o_sts.out_free     = !r_out_valid || i_out_ready;
    assign o_sts.mode         = r_mode;
    assign o_sts.stack_empty  = (r_depth == '0);
    assign o_sts.top_rem_zero = (top_rem == '0);
    assign o_sts.nbr_visited  = r_visited[r_rd_data];

    // item latch and list fill snapshots
    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD) begin
            r_mode <= i_mode;
            r_va   <= i_first_vertex;
            r_vb   <= i_second_vertex;
        end
        if (i_op == OP_READ_CNT_A) r_cnt_a <= cnt_rd;
        if (i_op == OP_READ_CNT_B) r_cnt_b <= cnt_rd;
    end

    // config, list counts, marks, stack depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount  <= VCOUNT_RESET;
            r_visited <= '0;
            r_depth   <= '0;
            for (int i = 0; i < MAX_VERTICES; i++) r_count[i] <= '0;
        end else begin
            if (i_cfg_we) r_vcount <= i_cfg_wdata;
            case (i_op)
                OP_WRITE_A: r_count[r_va] <= r_cnt_a + CNT_W'(1);
                OP_WRITE_B: r_count[r_vb] <= cnt_rd + CNT_W'(1);
                OP_START: begin
                    r_visited[r_va] <= 1'b1;
                    r_depth         <= SP_W'(1);
                end
                OP_POP: r_depth <= top_pos;
                OP_VISIT: begin
                    r_visited[r_rd_data] <= 1'b1;
                    if (r_depth < SP_W'(MAX_VERTICES)) r_depth <= r_depth + SP_W'(1);
                end
                default: ;
            endcase
        end
    end

    // stack entries and pending vertex
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_START: begin
                r_stk_v[0]   <= r_va;
                r_stk_rem[0] <= cnt_rd;
                r_pend       <= r_va;
            end
            OP_FETCH: r_stk_rem[top_idx] <= top_rem_dec;
            OP_VISIT: begin
                if (r_depth < SP_W'(MAX_VERTICES)) begin
                    r_stk_v[push_idx]   <= r_rd_data;
                    r_stk_rem[push_idx] <= cnt_rd;
                end
                r_pend <= r_rd_data;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            case (i_op) inside
                OP_EMIT_RANGE, OP_EMIT_FULL, OP_WRITE_B, OP_VISIT, OP_FINISH:
                    r_out_valid <= 1'b1;
                default: if (i_out_ready) r_out_valid <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_EMIT_RANGE: begin
                r_out_status <= ST_RANGE;
                r_out_vertex <= '0;
                r_out_last   <= 1'b1;
            end
            OP_EMIT_FULL: begin
                r_out_status <= ST_FULL;
                r_out_vertex <= '0;
                r_out_last   <= 1'b1;
            end
            OP_WRITE_B: begin
                r_out_status <= ST_ADDED;
                r_out_vertex <= '0;
                r_out_last   <= 1'b1;
            end
            OP_VISIT: begin
                r_out_status <= ST_VISIT;
                r_out_vertex <= r_pend;
                r_out_last   <= 1'b0;
            end
            OP_FINISH: begin
                r_out_status <= ST_VISIT;
                r_out_vertex <= r_pend;
                r_out_last   <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_visited_vertex = r_out_vertex;
    assign o_last           = r_out_last;

endmodule

// ===== src/graph_depth_first_walk_core.sv =====
// Top level of the depth-first graph walk core: controller plus datapath.
// Depends on gdfw_pkg, gdfw_ctrl, gdfw_dp.
//
// Input channel (i_in_valid/o_in_ready): one item is i_mode, i_first_vertex,
//   i_second_vertex. Mode 0 adds an undirected edge, mode 1 walks
//   depth-first from i_first_vertex. Items are taken one at a time.
// Output channel (o_out_valid/i_out_ready): an edge item gives one item
//   (added, list full, or out of range); a walk gives one item per visited
//   vertex in visiting order, o_last set on the final one.
// Config: i_cfg_we/i_cfg_wdata write vertex_count; write only when idle.
// Steps per item, from accept to the next accept, with no stalls:
//   out of range: accept, decode; edge rejected as full: accept, two count
//   reads, a check; edge added: one more step for the second table write on
//   the single port; walk: accept and start, then for each list entry
//   scanned a registered table read and a check, for each stack entry a
//   pop, plus the final emission.
// Reset: list counts, visited marks and stack depth clear; vertex_count
//   returns to 16. Marks persist between walks until the next reset.
// Stall: one output register; while it is held the controller waits at its
//   next emission, so nothing is lost or dropped.
module graph_depth_first_walk_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gdfw_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [gdfw_pkg::VTX_W-1:0]    i_first_vertex,
    input  logic [gdfw_pkg::VTX_W-1:0]    i_second_vertex,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [gdfw_pkg::STATUS_W-1:0] o_status,
    output logic [gdfw_pkg::VTX_W-1:0]    o_visited_vertex,
    output logic                          o_last
);
    import gdfw_pkg::*;

    t_dp_op  dp_op;
    t_dp_sts dp_sts;

    // sequencing: accept, decode, edge steps, walk loop
    gdfw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_op       (dp_op)
    );

    // storage and result register
    gdfw_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (dp_op),
        .o_sts            (dp_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_mode           (i_mode),
        .i_first_vertex   (i_first_vertex),
        .i_second_vertex  (i_second_vertex),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_visited_vertex (o_visited_vertex),
        .o_last           (o_last)
    );

endmodule

// ===== src/gdfw_checker.sv =====
// Port-level checks for the depth-first walk core, bound to the top level.
// Depends on gdfw_pkg and graph_depth_first_walk_core.
module gdfw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [gdfw_pkg::STATUS_W-1:0] o_status,
    input logic [gdfw_pkg::VTX_W-1:0]    o_visited_vertex,
    input logic                          o_last
);
    import gdfw_pkg::*;

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_visited_vertex) && $stable(o_last))
        else $error("output item changed while stalled");

    // edge and reject results are always the only result of their item
    a_non_visit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_VISIT) |-> o_last)
        else $error("non-visit result without last");

    a_non_visit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_VISIT) |-> (o_visited_vertex == '0))
        else $error("non-visit result carries a vertex");

    // one item in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item accepted while busy");

endmodule

bind graph_depth_first_walk_core gdfw_checker u_gdfw_checker (.*);
